>>> rtl/core/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, codes and the attenuation table of the sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

   // input word kinds, carried on req_tuser
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_STEREO = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   // configuration register indexes
   localparam logic CSR_TAP_MASK = 1'b0;
   localparam logic CSR_FEED_POS = 1'b1;

   localparam logic [15:0] TAP_MASK_RESET = 16'h0009;
   localparam logic [3:0]  FEED_POS_RESET = 4'd15;

   localparam int          CHANNELS    = 4;
   localparam logic [1:0]  NOISE_CH    = 2'd3;
   localparam logic [1:0]  RATE_TONE2  = 2'd3;
   localparam int          LATCH_BIT   = 7;
   localparam int          LEVEL_W     = 14;
   localparam int          HELD_W      = 16;
   localparam int          SUM_W       = 17;
   localparam int          CNT_W       = 11;
   localparam int          PERIOD_W    = 10;

   typedef struct packed {
      logic                valid;
      logic [1:0]          ch;
      logic [PERIOD_W-1:0] period;
      logic [3:0]          atten;
      logic                left_on;
      logic                right_on;
   } psg_issue_type;

   typedef struct packed {
      logic [CNT_W-1:0]         counter;
      logic                     polarity;
      logic signed [HELD_W-1:0] held_left;
      logic signed [HELD_W-1:0] held_right;
   } psg_entry_type;

   localparam psg_entry_type ENTRY_RESET = '{
      counter: '0, polarity: 1'b1, held_left: '0, held_right: '0};

   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] left;
      logic signed [SUM_W-1:0] right;
   } psg_result_type;

   function automatic logic [LEVEL_W-1:0] level_of(input logic [3:0] atten);
      logic [LEVEL_W-1:0] lvl;
      unique case (atten)
         4'd0:  lvl = 14'd16383;
         4'd1:  lvl = 14'd13014;
         4'd2:  lvl = 14'd10337;
         4'd3:  lvl = 14'd8211;
         4'd4:  lvl = 14'd6522;
         4'd5:  lvl = 14'd5181;
         4'd6:  lvl = 14'd4115;
         4'd7:  lvl = 14'd3284;
         4'd8:  lvl = 14'd2596;
         4'd9:  lvl = 14'd2062;
         4'd10: lvl = 14'd1638;
         4'd11: lvl = 14'd1301;
         4'd12: lvl = 14'd1033;
         4'd13: lvl = 14'd821;
         4'd14: lvl = 14'd652;
         default: lvl = 14'd0;
      endcase
      return lvl;
   endfunction

endpackage

>>> rtl/core/psg_sound_generator.sv
// ----------------------------------------------------------------------------
// psg_sound_generator
// Three tone channels and one noise channel mixed into signed stereo levels.
// ----------------------------------------------------------------------------
// A tick word visits the channels one channel per cycle through the single read
// port of the channel state memory; its mixed result goes into a two-entry queue
// that drives rsp. Any word is held off while the channels of a tick are still
// issuing and while two results are queued or in flight.
// Synchronous reset clears control state; channel memory entries read as their
// reset value until written back, so no clearing pass is needed.
module psg_sound_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [16:0] left_level, [33:17] right_level
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import psg_pkg::*;

   logic [15:0] tap_ff;
   logic [3:0]  feed_ff;
   logic [PERIOD_W-1:0] tp_ff [3];
   logic [3:0]  att_ff [CHANNELS];
   logic [7:0]  side_ff;
   logic [1:0]  rate_ff;
   logic        white_ff;
   logic [1:0]  sel_ch_ff;
   logic        sel_vol_ff;
   logic        busy_ff;
   logic [1:0]  iss_ch_ff;
   logic        pending_ff;
   logic [2*SUM_W-1:0] q_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;

   logic        accept, tick_acc, reg_acc, latch, eff_vol, noise_load;
   logic [1:0]  eff_ch;
   logic [5:0]  wdata;
   logic        push, pop;
   psg_issue_type  iss;
   psg_result_type res;

   assign accept   = req_tvalid && req_tready;
   assign tick_acc = accept && (req_tuser == KIND_TICK);
   assign reg_acc  = accept && (req_tuser == KIND_WRITE);
   assign latch    = req_tdata[LATCH_BIT];
   assign eff_ch   = latch ? req_tdata[6:5] : sel_ch_ff;
   assign eff_vol  = latch ? req_tdata[4] : sel_vol_ff;
   assign wdata    = latch ? {2'b00, req_tdata[3:0]} : req_tdata[5:0];
   assign noise_load = reg_acc && !eff_vol && (eff_ch == NOISE_CH);

   assign req_tready = !busy_ff && ((count_ff + {1'b0, pending_ff}) < 2'd2);

   // channel 0 issues in the accept cycle, 1..3 follow
   always_comb begin
      iss.valid = tick_acc || busy_ff;
      iss.ch    = busy_ff ? iss_ch_ff : 2'd0;
      iss.atten = att_ff[iss.ch];
      iss.left_on  = side_ff[{1'b1, iss.ch}];
      iss.right_on = side_ff[{1'b0, iss.ch}];
      if (iss.ch != NOISE_CH) begin
         iss.period = tp_ff[iss.ch];
      end else begin
         unique case (rate_ff)
            2'd0:    iss.period = PERIOD_W'(16);
            2'd1:    iss.period = PERIOD_W'(32);
            2'd2:    iss.period = PERIOD_W'(64);
            default: iss.period = tp_ff[2];
         endcase
      end
   end

   psg_chan_unit u_chan (
      .clock      (clock),
      .reset      (reset),
      .iss        (iss),
      .noise_load (noise_load),
      .feed_pos   (feed_ff),
      .tap_mask   (tap_ff),
      .white_mode (white_ff),
      .res        (res)
   );

   assign push = res.valid;
   assign pop  = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {6'b0, q_ff[rd_ptr_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff     <= TAP_MASK_RESET;
         feed_ff    <= FEED_POS_RESET;
         for (int i = 0; i < 3; i++) begin
            tp_ff[i] <= '0;
         end
         for (int i = 0; i < CHANNELS; i++) begin
            att_ff[i] <= 4'hF;
         end
         side_ff    <= 8'hFF;
         rate_ff    <= 2'd0;
         white_ff   <= 1'b0;
         sel_ch_ff  <= 2'd0;
         sel_vol_ff <= 1'b0;
         busy_ff    <= 1'b0;
         iss_ch_ff  <= 2'd0;
         pending_ff <= 1'b0;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         count_ff   <= 2'd0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TAP_MASK: tap_ff  <= csr_wdata;
               CSR_FEED_POS: feed_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (reg_acc) begin
            if (latch) begin
               sel_ch_ff  <= eff_ch;
               sel_vol_ff <= eff_vol;
            end
            if (eff_vol) begin
               att_ff[eff_ch] <= wdata[3:0];
            end else if (eff_ch == NOISE_CH) begin
               rate_ff  <= wdata[1:0];
               white_ff <= wdata[2];
            end else if (latch) begin
               tp_ff[eff_ch][3:0] <= wdata[3:0];
            end else begin
               tp_ff[eff_ch][PERIOD_W-1:4] <= wdata;
            end
         end
         if (accept && req_tuser == KIND_STEREO) begin
            side_ff <= req_tdata;
         end
         // advance the channel sequencer
         if (tick_acc) begin
            busy_ff   <= 1'b1;
            iss_ch_ff <= 2'd1;
         end else if (busy_ff) begin
            busy_ff   <= (iss_ch_ff != NOISE_CH);
            iss_ch_ff <= iss_ch_ff + 2'd1;
         end
         if (tick_acc) begin
            pending_ff <= 1'b1;
         end else if (push) begin
            pending_ff <= 1'b0;
         end
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= {res.right, res.left};
      end
   end

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue over capacity");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < 2'd2 || pop))
      else $error("result pushed into full queue");

   a_tick_blocks: assert property (@(posedge clock) disable iff (reset)
      tick_acc |=> !req_tready)
      else $error("word taken while channels still issuing");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      tick_acc |-> ##4 push)
      else $error("tick did not produce a result after four channels");

endmodule

>>> rtl/core/psg_chan_unit.sv
// ----------------------------------------------------------------------------
// psg_chan_unit
// Per-channel state memory with read-modify-write of one channel a cycle,
// noise shift register and the left/right mix accumulator.
// ----------------------------------------------------------------------------
module psg_chan_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  psg_pkg::psg_issue_type  iss,
   input  logic                    noise_load,
   input  logic [3:0]              feed_pos,
   input  logic [15:0]             tap_mask,
   input  logic                    white_mode,
   output psg_pkg::psg_result_type res
);
   import psg_pkg::*;

   psg_entry_type mem [CHANNELS];
   logic [CHANNELS-1:0] vld_ff;
   psg_entry_type rd_ff;
   logic          rd_vld_ff;
   psg_issue_type stb_ff;

   logic [15:0] sr_ff, sr_in;
   logic        tog_ff, tog_in;
   logic signed [SUM_W-1:0] acc_l_ff, acc_r_ff, acc_l_in, acc_r_in;

   psg_entry_type cur, nxt;
   logic [LEVEL_W-1:0]       lvl;
   logic signed [HELD_W-1:0] amp, signed_amp;
   logic [CNT_W-1:0]         per;
   logic                     fb;

   always_comb begin
      cur = rd_vld_ff ? rd_ff : ENTRY_RESET;
      nxt = cur;
      sr_in = sr_ff;
      tog_in = tog_ff;
      fb = 1'b0;
      lvl = level_of(stb_ff.atten);
      if (stb_ff.ch != NOISE_CH) begin
         lvl = lvl >> 1;
      end
      amp = HELD_W'(signed'({1'b0, lvl}));
      per = CNT_W'(stb_ff.period);
      signed_amp = amp;
      if (stb_ff.valid && per != '0) begin
         if (per != CNT_W'(1)) begin
            if (cur.counter <= CNT_W'(1)) begin
               nxt.counter = cur.counter + per - CNT_W'(1);
               if (stb_ff.ch == NOISE_CH) begin
                  tog_in = ~tog_ff;
                  if (tog_in) begin
                     fb = white_mode ? ^(sr_ff & tap_mask) : sr_ff[0];
                     sr_in = (sr_ff >> 1) | (16'(fb) << feed_pos);
                     nxt.polarity = sr_in[0];
                  end
               end else begin
                  nxt.polarity = ~cur.polarity;
               end
            end else begin
               nxt.counter = cur.counter - CNT_W'(1);
            end
            signed_amp = nxt.polarity ? amp : -amp;
         end
         nxt.held_left  = stb_ff.left_on  ? signed_amp : '0;
         nxt.held_right = stb_ff.right_on ? signed_amp : '0;
      end
      // a control write lands after the tick in the same cycle
      if (noise_load) begin
         sr_in = 16'(1) << feed_pos;
         tog_in = 1'b1;
      end
      acc_l_in = ((stb_ff.ch == 2'd0) ? '0 : acc_l_ff) + SUM_W'(nxt.held_left);
      acc_r_in = ((stb_ff.ch == 2'd0) ? '0 : acc_r_ff) + SUM_W'(nxt.held_right);
   end

   assign res.valid = stb_ff.valid && (stb_ff.ch == NOISE_CH);
   assign res.left  = acc_l_in;
   assign res.right = acc_r_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         stb_ff <= '0;
         vld_ff <= '0;
         rd_vld_ff <= 1'b0;
         sr_ff <= 16'(1) << FEED_POS_RESET;
         tog_ff <= 1'b1;
      end else begin
         stb_ff <= iss;
         sr_ff <= sr_in;
         tog_ff <= tog_in;
         if (iss.valid) begin
            rd_vld_ff <= vld_ff[iss.ch];
         end
         if (stb_ff.valid) begin
            vld_ff[stb_ff.ch] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (iss.valid) begin
         rd_ff <= mem[iss.ch];
      end
      if (stb_ff.valid) begin
         mem[stb_ff.ch] <= nxt;
         acc_l_ff <= acc_l_in;
         acc_r_ff <= acc_r_in;
      end
   end

endmodule
